// ===== src/rca_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotating channel allocator package
// Shared constants, command and status codes, and the control and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rca_pkg;

    // Number of bearer channels on the link, one mask bit per channel.
    localparam int CHANNELS = 32;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int CNT_W    = 6;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Reset value of the voice channel mask: framing and signalling slots off.
    localparam logic [CHANNELS-1:0] VOICE_RESET = CHANNELS'(32'hFFFE_FFFE);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOICE_MASK = 2'd0,
        REG_OUT_BLOCK  = 2'd1,
        REG_IN_BLOCK   = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg_idx;

    // Command codes of an input word.
    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_CAPTURE = 2'd1,
        CMD_FREE    = 2'd2,
        CMD_RESTART = 2'd3
    } t_command;

    // Status codes of a result word.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LINK_DOWN = 3'd1,
        ST_NO_FREE   = 3'd2,
        ST_SET_BUSY  = 3'd3,
        ST_NOT_BUSY  = 3'd4
    } t_status;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_item;
        logic scan_init;
        logic scan_step;
        logic wrap_step;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic alloc_go;
        logic scan_last;
    } t_dp_stat;

endpackage

// ===== src/rca_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rotating channel allocator controller
// Sequences one input word through decode, the channel scan and the result
// register, and runs the handshakes of both channels.
// ----------------------------------------------------------------------------
module rca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rca_pkg::t_dp_stat i_stat,
    output rca_pkg::t_dp_cmd  o_cmd
);
    import rca_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WRAP,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_commit;

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    // A result may be loaded once the output register is empty or draining.
    assign w_accept = i_in_valid && r_in_ready;
    assign w_commit = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Commands to the datapath follow from the state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.load_item = w_accept;
        o_cmd.scan_init = (r_state == S_DECODE) && i_stat.alloc_go;
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.wrap_step = (r_state == S_WRAP);
        o_cmd.commit    = w_commit;
    end

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills on commit and empties when taken.
            r_out_valid <= w_commit || (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE: begin
                    r_in_ready <= !w_accept;
                    if (w_accept) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_state <= i_stat.alloc_go ? S_SCAN : S_DONE;
                end
                S_SCAN: begin
                    if (i_stat.scan_last) begin
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_commit) begin
                        r_in_ready <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/rca_dp.sv =====
// ----------------------------------------------------------------------------
// Rotating channel allocator datapath
// Holds the configuration masks, the busy mask and rotation point, the
// captured input word, the channel scan registers and the result register.
// ----------------------------------------------------------------------------
module rca_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rca_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rca_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [1:0]                     i_command,
    input  logic [rca_pkg::CNT_W-1:0]      i_channel_count,
    input  logic                           i_outgoing,
    input  logic [rca_pkg::CHANNELS-1:0]   i_channel_set,
    input  logic                           i_link_active,
    input  rca_pkg::t_dp_cmd               i_cmd,
    output rca_pkg::t_dp_stat              o_stat,
    output logic [2:0]                     o_status,
    output logic [rca_pkg::CHANNELS-1:0]   o_granted_channels,
    output logic [rca_pkg::CHANNELS-1:0]   o_busy_channels
);
    import rca_pkg::*;

    // Configuration and persistent state.
    logic [CHANNELS-1:0] r_voice;
    logic [CHANNELS-1:0] r_out_block;
    logic [CHANNELS-1:0] r_in_block;
    logic [CHANNELS-1:0] r_busy;
    logic [CH_W-1:0]     r_rot_point;
    logic                r_rot_valid;

    // Captured input word.
    t_command            r_cmd;
    logic [CNT_W-1:0]    r_want;
    logic                r_outgoing;
    logic [CHANNELS-1:0] r_set;
    logic                r_link;

    // Scan registers.
    logic [CH_W-1:0]     r_ch;
    logic [CH_W-1:0]     r_step;
    logic [CNT_W-1:0]    r_got;
    logic [CHANNELS-1:0] r_grant;
    logic [CH_W-1:0]     r_first;
    logic                r_skip;
    logic [CH_W-1:0]     r_defer_ch;
    logic                r_defer_ok;

    // Result register.
    t_status             r_status;
    logic [CHANNELS-1:0] r_granted;
    logic [CHANNELS-1:0] r_busy_out;

    logic [CHANNELS-1:0] w_free;
    logic                w_ch_free;
    logic                w_need_more;
    logic [CH_W-1:0]     w_next_ch;
    logic [CH_W-1:0]     w_start_ch;
    t_status             n_status;
    logic [CHANNELS-1:0] n_granted;
    logic [CHANNELS-1:0] n_busy;
    logic [CH_W-1:0]     n_rot_point;
    logic                n_rot_valid;

    assign o_status           = r_status;
    assign o_granted_channels = r_granted;
    assign o_busy_channels    = r_busy_out;

    // Free channels for the direction of the held word.
    assign w_free = r_voice & ~r_busy & ~(r_outgoing ? r_out_block : r_in_block);

    assign w_ch_free   = w_free[r_ch];
    assign w_need_more = (r_got < r_want);
    assign w_next_ch   = (r_ch == CH_W'(CHANNELS - 1)) ? '0 : CH_W'(r_ch + 1'b1);
    assign w_start_ch  = (r_rot_point == CH_W'(CHANNELS - 1)) ? '0
                                                              : CH_W'(r_rot_point + 1'b1);

    assign o_stat.alloc_go  = (r_cmd == CMD_ALLOC) && r_link && (r_want != '0);
    assign o_stat.scan_last = (r_step == CH_W'(CHANNELS - 1));

    // Result and next state of the held command.
    always_comb begin
        n_status    = ST_OK;
        n_granted   = '0;
        n_busy      = r_busy;
        n_rot_point = r_rot_point;
        n_rot_valid = r_rot_valid;
        unique case (r_cmd)
            CMD_ALLOC: begin
                if (!r_link) begin
                    n_status = ST_LINK_DOWN;
                end else if ((r_want == '0) || (r_got != r_want)) begin
                    n_status = ST_NO_FREE;
                end else begin
                    n_granted   = r_grant;
                    n_busy      = r_busy | r_grant;
                    n_rot_point = r_first;
                    n_rot_valid = 1'b1;
                end
            end
            CMD_CAPTURE: begin
                if ((r_set & ~w_free) != '0) begin
                    n_status = ST_SET_BUSY;
                end else begin
                    n_granted = r_set;
                    n_busy    = r_busy | r_set;
                end
            end
            CMD_FREE: begin
                if ((r_set & ~r_busy) != '0) begin
                    n_status = ST_NOT_BUSY;
                end
                n_busy = r_busy & ~r_set;
            end
            CMD_RESTART: begin
                n_rot_point = '0;
                n_rot_valid = 1'b0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Configuration, busy mask and rotation point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice     <= VOICE_RESET;
            r_out_block <= '0;
            r_in_block  <= '0;
            r_busy      <= '0;
            r_rot_point <= '0;
            r_rot_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_VOICE_MASK: r_voice     <= CHANNELS'(i_cfg_data);
                    REG_OUT_BLOCK:  r_out_block <= CHANNELS'(i_cfg_data);
                    REG_IN_BLOCK:   r_in_block  <= CHANNELS'(i_cfg_data);
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_busy      <= n_busy;
                r_rot_point <= n_rot_point;
                r_rot_valid <= n_rot_valid;
            end
        end
    end

    // Input word capture, channel scan and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd      <= t_command'(i_command);
            r_want     <= i_channel_count;
            r_outgoing <= i_outgoing;
            r_set      <= i_channel_set;
            r_link     <= i_link_active;
        end

        // Without a rotation point, the scan runs from channel zero and holds
        // back the lowest free channel so that it is taken last.
        if (i_cmd.scan_init) begin
            r_ch       <= r_rot_valid ? w_start_ch : '0;
            r_skip     <= !r_rot_valid;
            r_step     <= '0;
            r_got      <= '0;
            r_grant    <= '0;
            r_first    <= '0;
            r_defer_ok <= 1'b0;
        end

        if (i_cmd.scan_step) begin
            r_ch   <= w_next_ch;
            r_step <= CH_W'(r_step + 1'b1);
            if (r_skip && w_ch_free) begin
                r_skip     <= 1'b0;
                r_defer_ch <= r_ch;
                r_defer_ok <= 1'b1;
            end else if (w_ch_free && w_need_more) begin
                r_grant[r_ch] <= 1'b1;
                r_got         <= CNT_W'(r_got + 1'b1);
                if (r_got == '0) begin
                    r_first <= r_ch;
                end
            end
        end

        // The held-back lowest channel closes the wrapped scan.
        if (i_cmd.wrap_step && r_defer_ok && w_need_more) begin
            r_grant[r_defer_ch] <= 1'b1;
            r_got               <= CNT_W'(r_got + 1'b1);
            if (r_got == '0) begin
                r_first <= r_defer_ch;
            end
        end

        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_granted  <= n_granted;
            r_busy_out <= n_busy;
        end
    end

endmodule

// ===== src/rotating_channel_allocator.sv =====
// ----------------------------------------------------------------------------
// Rotating channel allocator
// Allocates, captures and frees bearer channels of one TDM link, granting
// channels for allocate-any in rotating order.
// ----------------------------------------------------------------------------
//  Channel   Handshake                     Word
//  input     i_in_valid / o_in_ready       command, count, direction, set, link
//  output    o_out_valid / i_out_ready     status, granted mask, busy mask
//  config    i_cfg_we (no wait)            register index and 32-bit data
//
// An allocate-any with the link up and a nonzero count runs the whole channel
// scan before its result, even when too few channels turn out to be free: the
// scan visits one channel per cycle over all 32 channels and then places the
// held-back lowest channel, if one was held back. Every other word goes from
// decode straight to the result register. The next word is accepted in the
// cycle after a result is loaded. Reset is synchronous and active low; it
// restores the configuration masks and clears the busy mask and rotation
// point. A new word is accepted while an earlier result still waits in the
// output register; a finished result then waits until that register drains.
// ----------------------------------------------------------------------------
module rotating_channel_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rca_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rca_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_command,
    input  logic [rca_pkg::CNT_W-1:0]      i_channel_count,
    input  logic                           i_outgoing,
    input  logic [rca_pkg::CHANNELS-1:0]   i_channel_set,
    input  logic                           i_link_active,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_status,
    output logic [rca_pkg::CHANNELS-1:0]   o_granted_channels,
    output logic [rca_pkg::CHANNELS-1:0]   o_busy_channels
);
    import rca_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencing and handshakes.
    rca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Masks, scan and result.
    rca_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_command          (i_command),
        .i_channel_count    (i_channel_count),
        .i_outgoing         (i_outgoing),
        .i_channel_set      (i_channel_set),
        .i_link_active      (i_link_active),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .o_status           (o_status),
        .o_granted_channels (o_granted_channels),
        .o_busy_channels    (o_busy_channels)
    );

endmodule
